// ----- sv/awp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package awp_pkg;

   // Source frame and output frame geometry.
   localparam int MAX_SRC_DIM = 256;
   localparam int OUT_SIZE    = 112;
   localparam int COORD_W     = 8;
   localparam int PIX_W       = 24;
   localparam int BANK_AW     = 2 * (COORD_W - 1);
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      REG_COEF_XX    = 3'd0,
      REG_COEF_XY    = 3'd1,
      REG_OFFSET_X   = 3'd2,
      REG_COEF_YX    = 3'd3,
      REG_COEF_YY    = 3'd4,
      REG_OFFSET_Y   = 3'd5,
      REG_SRC_WIDTH  = 3'd6,
      REG_SRC_HEIGHT = 3'd7
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD    = 1'b0,
      FUNC_REQUEST = 1'b1
   } func_type;

   typedef struct packed {
      logic               func;
      logic [7:0]         pos_col;
      logic [7:0]         pos_row;
      logic [7:0]         in_red;
      logic [7:0]         in_green;
      logic [7:0]         in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_col;
      logic [7:0] out_row;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } rsp_type;

   // One queued transaction: a pixel load or an in-frame request.
   typedef struct packed {
      logic               is_load;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [PIX_W-1:0]   rgb;
   } item_type;

   // Affine matrix and last valid source index on each axis.
   typedef struct packed {
      logic signed [31:0] coef_xx;
      logic signed [31:0] coef_xy;
      logic signed [31:0] offset_x;
      logic signed [31:0] coef_yx;
      logic signed [31:0] coef_yy;
      logic signed [31:0] offset_y;
      logic [COORD_W-1:0] col_max;
      logic [COORD_W-1:0] row_max;
   } cfg_type;

endpackage
`default_nettype wire

// ----- sv/awp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module awp_front
   import awp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_data,
   input  wire logic     q_full,
   output logic          q_push,
   output item_type      q_item
);

   logic in_frame;

   // Requests outside the output frame are consumed and dropped here.
   always_comb begin
      in_frame = ({24'd0, req_data.pos_col} < 32'(OUT_SIZE)) &&
                 ({24'd0, req_data.pos_row} < 32'(OUT_SIZE));
      req_stall = q_full;
      q_push = req_valid && !q_full && !reset &&
               ((req_data.func == FUNC_LOAD) || in_frame);
      q_item.is_load = (req_data.func == FUNC_LOAD);
      q_item.col     = req_data.pos_col;
      q_item.row     = req_data.pos_row;
      q_item.rgb     = {req_data.in_blue, req_data.in_green, req_data.in_red};
   end

   logic unused_clock;
   assign unused_clock = clock;

endmodule
`default_nettype wire

// ----- sv/awp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module awp_queue
   import awp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          pop_valid,
   output item_type      pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 do_pop;

   // Pointer and fill count update.
   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
      full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
      pop_valid = (count_ff != '0);
      pop_item  = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ----- sv/awp_frame.sv -----
`timescale 1ns / 1ps
`default_nettype none
module awp_frame
   import awp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic               wr_en,
   input  wire logic [COORD_W-1:0] wr_col,
   input  wire logic [COORD_W-1:0] wr_row,
   input  wire logic [PIX_W-1:0]   wr_data,
   input  wire logic [BANK_AW-1:0] rd_addr [4],
   output logic      [PIX_W-1:0]   rd_data [4]
);

   // Four banks split by column and row parity, so any 2x2 neighborhood
   // touches each bank at most once. Bank index is {row[0], col[0]}.
   logic [1:0]         wr_bank;
   logic [BANK_AW-1:0] wr_addr;

   assign wr_bank = {wr_row[0], wr_col[0]};
   assign wr_addr = {wr_row[COORD_W-1:1], wr_col[COORD_W-1:1]};

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [PIX_W-1:0] mem [2**BANK_AW];

      always_ff @(posedge clock) begin
         if (enable && wr_en && (wr_bank == 2'(b))) begin
            mem[wr_addr] <= wr_data;
         end
         if (enable) begin
            rd_data[b] <= mem[rd_addr[b]];
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/awp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module awp_back
   import awp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     q_valid,
   input  wire item_type q_item,
   output logic          q_pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   // Saturate a floored source coordinate to 0..max.
   function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [25:0] c,
                                                      input logic [COORD_W-1:0] cmax);
      logic [COORD_W-1:0] r;
      if (c[25]) begin
         r = '0;
      end else if (c > $signed({18'd0, cmax})) begin
         r = cmax;
      end else begin
         r = c[COORD_W-1:0];
      end
      return r;
   endfunction

   logic enable;

   // Stage 1: the four matrix products.
   logic               s1_vld_ff;
   item_type           s1_item_ff;
   logic signed [40:0] s1_pxx_ff, s1_pxy_ff, s1_pyx_ff, s1_pyy_ff;
   // Stage 2: source point sums.
   logic               s2_vld_ff;
   item_type           s2_item_ff;
   logic signed [41:0] s2_sx_ff, s2_sy_ff;
   // Stage 3: clamped neighbors and corner weights.
   logic               s3_vld_ff;
   item_type           s3_item_ff;
   logic [COORD_W-1:0] s3_xa_ff, s3_xb_ff, s3_ya_ff, s3_yb_ff;
   logic [16:0]        s3_w_ff [4];
   // Stage 4: frame read.
   logic               s4_vld_ff;
   logic [COORD_W-1:0] s4_col_ff, s4_row_ff;
   logic [3:0]         s4_par_ff;
   logic [16:0]        s4_w_ff [4];
   // Stage 5: blend sums.
   logic               s5_vld_ff;
   logic [COORD_W-1:0] s5_col_ff, s5_row_ff;
   logic [23:0]        s5_acc_ff [3];
   // Output register.
   logic               out_vld_ff;
   rsp_type            out_ff;

   assign enable    = !out_vld_ff || !rsp_stall;
   assign q_pop     = enable;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // Valid bits advance together whenever the output can move.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (enable) begin
         s1_vld_ff  <= q_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff && !s3_item_ff.is_load;
         s5_vld_ff  <= s4_vld_ff;
         out_vld_ff <= s5_vld_ff;
      end
   end

   // Stage 1 and 2 datapath.
   always_ff @(posedge clock) begin
      if (enable) begin
         s1_item_ff <= q_item;
         s1_pxx_ff  <= cfg.coef_xx * $signed({1'b0, q_item.col});
         s1_pxy_ff  <= cfg.coef_xy * $signed({1'b0, q_item.row});
         s1_pyx_ff  <= cfg.coef_yx * $signed({1'b0, q_item.col});
         s1_pyy_ff  <= cfg.coef_yy * $signed({1'b0, q_item.row});
         s2_item_ff <= s1_item_ff;
         s2_sx_ff   <= 42'(s1_pxx_ff) + 42'(s1_pxy_ff) + 42'(cfg.offset_x);
         s2_sy_ff   <= 42'(s1_pyx_ff) + 42'(s1_pyy_ff) + 42'(cfg.offset_y);
      end
   end

   // Stage 3: floor, clamp and weight products.
   logic signed [25:0] x0, y0;
   logic [8:0]         fx, fy, gx, gy;
   logic [17:0]        w00, w10, w01, w11;

   always_comb begin
      x0  = s2_sx_ff[41:16];
      y0  = s2_sy_ff[41:16];
      fx  = {1'b0, s2_sx_ff[15:8]};
      fy  = {1'b0, s2_sy_ff[15:8]};
      gx  = 9'd256 - fx;
      gy  = 9'd256 - fy;
      w00 = gx * gy;
      w10 = fx * gy;
      w01 = gx * fy;
      w11 = fx * fy;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s3_item_ff <= s2_item_ff;
         s3_xa_ff   <= clamp_coord(x0, cfg.col_max);
         s3_xb_ff   <= clamp_coord(x0 + 26'sd1, cfg.col_max);
         s3_ya_ff   <= clamp_coord(y0, cfg.row_max);
         s3_yb_ff   <= clamp_coord(y0 + 26'sd1, cfg.row_max);
         s3_w_ff[0] <= w00[16:0];
         s3_w_ff[1] <= w10[16:0];
         s3_w_ff[2] <= w01[16:0];
         s3_w_ff[3] <= w11[16:0];
      end
   end

   // Bank addresses: each parity bank takes whichever neighbor has its parity.
   logic [BANK_AW-1:0] rd_addr [4];
   logic [PIX_W-1:0]   rd_data [4];

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         logic [COORD_W-1:0] cs, rs;
         cs = (s3_xa_ff[0] == b[0]) ? s3_xa_ff : s3_xb_ff;
         rs = (s3_ya_ff[0] == b[1]) ? s3_ya_ff : s3_yb_ff;
         rd_addr[b] = {rs[COORD_W-1:1], cs[COORD_W-1:1]};
      end
   end

   awp_frame u_frame (
      .clock   (clock),
      .enable  (enable),
      .wr_en   (s3_vld_ff && s3_item_ff.is_load),
      .wr_col  (s3_item_ff.col),
      .wr_row  (s3_item_ff.row),
      .wr_data (s3_item_ff.rgb),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (enable) begin
         s4_col_ff <= s3_item_ff.col;
         s4_row_ff <= s3_item_ff.row;
         s4_par_ff <= {s3_yb_ff[0], s3_ya_ff[0], s3_xb_ff[0], s3_xa_ff[0]};
         s4_w_ff   <= s3_w_ff;
      end
   end

   // Stage 5: route bank words to corners and blend each channel.
   logic [PIX_W-1:0] pix [4];
   logic [24:0]      acc [3];

   always_comb begin
      pix[0] = rd_data[{s4_par_ff[2], s4_par_ff[0]}];
      pix[1] = rd_data[{s4_par_ff[2], s4_par_ff[1]}];
      pix[2] = rd_data[{s4_par_ff[3], s4_par_ff[0]}];
      pix[3] = rd_data[{s4_par_ff[3], s4_par_ff[1]}];
      for (int c = 0; c < 3; c++) begin
         acc[c] = '0;
         for (int k = 0; k < 4; k++) begin
            acc[c] = acc[c] + 25'(pix[k][8*c +: 8]) * 25'(s4_w_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s5_col_ff <= s4_col_ff;
         s5_row_ff <= s4_row_ff;
         for (int c = 0; c < 3; c++) begin
            s5_acc_ff[c] <= acc[c][23:0];
         end
      end
   end

   // Output: round half up and saturate.
   logic [24:0] rnd [3];
   logic [7:0]  chan [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rnd[c]  = {1'b0, s5_acc_ff[c]} + 25'd32768;
         chan[c] = (rnd[c][24:16] > 9'd255) ? 8'd255 : rnd[c][23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff.out_col   <= s5_col_ff;
         out_ff.out_row   <= s5_row_ff;
         out_ff.out_red   <= chan[0];
         out_ff.out_green <= chan[1];
         out_ff.out_blue  <= chan[2];
      end
   end

endmodule
`default_nettype wire

// ----- sv/affine_bilinear_warp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Ports                              Direction  Payload
// req      req_valid / req_stall / req_data   in         req_type
// rsp      rsp_valid / rsp_stall / rsp_data   out        rsp_type
// csr      csr_we / csr_addr / csr_wdata      in         32-bit register write
//
// One transaction per cycle is sustained while rsp_stall does not hold the pipeline; a request's
// result passes the queue, two affine stages, clamp, bank read, blend and round registers.
// The frame is four parity banks, each read once per cycle while the back pipeline moves.
// Synchronous active-high reset empties the queue and pipeline; the frame
// holds undefined data until loaded. rsp_stall with a result waiting freezes the whole back
// pipeline; req_stall rises only when the four-entry queue is full.
module affine_bilinear_warp
   import awp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   logic [31:0] coef_ff [6];
   logic [8:0]  width_ff, height_ff;
   cfg_type     cfg;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_COEF_XX]  <= 32'd65536;
         coef_ff[REG_COEF_XY]  <= '0;
         coef_ff[REG_OFFSET_X] <= '0;
         coef_ff[REG_COEF_YX]  <= '0;
         coef_ff[REG_COEF_YY]  <= 32'd65536;
         coef_ff[REG_OFFSET_Y] <= '0;
         width_ff              <= 9'(MAX_SRC_DIM);
         height_ff             <= 9'(MAX_SRC_DIM);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            REG_COEF_XX, REG_COEF_XY, REG_OFFSET_X,
            REG_COEF_YX, REG_COEF_YY, REG_OFFSET_Y: begin
               coef_ff[csr_addr] <= csr_wdata;
            end
            REG_SRC_WIDTH:  width_ff  <= csr_wdata[8:0];
            REG_SRC_HEIGHT: height_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Size registers saturate to 1..MAX_SRC_DIM and become a last index.
   function automatic logic [COORD_W-1:0] last_index(input logic [8:0] s);
      logic [COORD_W-1:0] r;
      if (s == '0) begin
         r = '0;
      end else if ({23'd0, s} >= 32'(MAX_SRC_DIM)) begin
         r = COORD_W'(MAX_SRC_DIM - 1);
      end else begin
         r = s[COORD_W-1:0] - 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      cfg.coef_xx  = coef_ff[REG_COEF_XX];
      cfg.coef_xy  = coef_ff[REG_COEF_XY];
      cfg.offset_x = coef_ff[REG_OFFSET_X];
      cfg.coef_yx  = coef_ff[REG_COEF_YX];
      cfg.coef_yy  = coef_ff[REG_COEF_YY];
      cfg.offset_y = coef_ff[REG_OFFSET_Y];
      cfg.col_max  = last_index(width_ff);
      cfg.row_max  = last_index(height_ff);
   end

   logic     q_push, q_full, q_pop, q_valid;
   item_type q_in_item, q_out_item;

   awp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in_item)
   );

   awp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_out_item)
   );

   awp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_item    (q_out_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import awp_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;

   affine_bilinear_warp dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the block's registers and of the loaded frame.
   logic signed [31:0] mat_xx, mat_xy, mat_ox, mat_yx, mat_yy, mat_oy;
   logic [8:0]         frame_w, frame_h;
   logic [23:0]        shadow_frame [0:65535];

   rsp_type     pending_pixels[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          stall_rand;
   bit          gap_enable;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle counter that ends a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("affine_bilinear_warp regression: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic int clamp_axis(input longint c, input logic [8:0] size);
      longint s;
      s = size;
      if (s < 1) s = 1;
      if (s > MAX_SRC_DIM) s = MAX_SRC_DIM;
      if (c < 0) return 0;
      if (c > s - 1) return int'(s - 1);
      return int'(c);
   endfunction

   // Predicts one warped pixel from the shadow frame and matrix.
   function automatic rsp_type warp_pixel(input logic [7:0] col, input logic [7:0] row);
      rsp_type r;
      longint  sx, sy, x0, y0;
      int      fx, fy, gx, gy, xa, xb, ya, yb;
      logic [23:0] p00, p10, p01, p11;
      longint  acc, v;
      sx = longint'(mat_xx) * col + longint'(mat_xy) * row + longint'(mat_ox);
      sy = longint'(mat_yx) * col + longint'(mat_yy) * row + longint'(mat_oy);
      fx = int'((sx & 64'hFFFF) >> 8);
      fy = int'((sy & 64'hFFFF) >> 8);
      x0 = sx >>> 16;
      y0 = sy >>> 16;
      xa = clamp_axis(x0, frame_w);
      xb = clamp_axis(x0 + 1, frame_w);
      ya = clamp_axis(y0, frame_h);
      yb = clamp_axis(y0 + 1, frame_h);
      p00 = shadow_frame[ya * 256 + xa];
      p10 = shadow_frame[ya * 256 + xb];
      p01 = shadow_frame[yb * 256 + xa];
      p11 = shadow_frame[yb * 256 + xb];
      gx = 256 - fx;
      gy = 256 - fy;
      r.out_col = col;
      r.out_row = row;
      for (int c = 0; c < 3; c++) begin
         acc = longint'(p00[8*c +: 8]) * gx * gy + longint'(p10[8*c +: 8]) * fx * gy
             + longint'(p01[8*c +: 8]) * gx * fy + longint'(p11[8*c +: 8]) * fx * fy;
         v = (acc + 32768) >> 16;
         if (v > 255) v = 255;
         if (c == 0) r.out_blue = v[7:0];
         else if (c == 1) r.out_green = v[7:0];
         else r.out_red = v[7:0];
      end
      return r;
   endfunction

   // Compares each accepted result with the oldest expected pixel.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("result with no request waiting");
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.out_col !== want.out_col)
               report_mismatch($sformatf("out_col %0d want %0d", rsp_data.out_col, want.out_col));
            if (rsp_data.out_row !== want.out_row)
               report_mismatch($sformatf("out_row %0d want %0d", rsp_data.out_row, want.out_row));
            if (rsp_data.out_red !== want.out_red)
               report_mismatch($sformatf("red %0d want %0d at %0d,%0d",
                  rsp_data.out_red, want.out_red, want.out_col, want.out_row));
            if (rsp_data.out_green !== want.out_green)
               report_mismatch($sformatf("green %0d want %0d at %0d,%0d",
                  rsp_data.out_green, want.out_green, want.out_col, want.out_row));
            if (rsp_data.out_blue !== want.out_blue)
               report_mismatch($sformatf("blue %0d want %0d at %0d,%0d",
                  rsp_data.out_blue, want.out_blue, want.out_col, want.out_row));
         end
      end
   end

   // Receiver randomly holds rsp_stall high on a waiting result while stall_rand is set.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_rand && rsp_valid && !rsp_stall) begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Drops valid and waits until every transaction in flight has drained.
   task automatic idle_channel();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Register writes happen only with the block empty.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      idle_channel();
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         REG_COEF_XX:    mat_xx = value;
         REG_COEF_XY:    mat_xy = value;
         REG_OFFSET_X:   mat_ox = value;
         REG_COEF_YX:    mat_yx = value;
         REG_COEF_YY:    mat_yy = value;
         REG_OFFSET_Y:   mat_oy = value;
         REG_SRC_WIDTH:  frame_w = value[8:0];
         REG_SRC_HEIGHT: frame_h = value[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Sends one transaction; valid stays high across back-to-back items.
   task automatic send_item(input req_type item);
      int gap;
      gap = gap_enable ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.func == FUNC_LOAD) begin
         shadow_frame[{item.pos_row, item.pos_col}] =
            {item.in_red, item.in_green, item.in_blue};
      end else if (item.pos_col < OUT_SIZE && item.pos_row < OUT_SIZE) begin
         pending_pixels.push_back(warp_pixel(item.pos_col, item.pos_row));
      end
      @(negedge clock);
   endtask

   task automatic load_pixel(input int col, input int row,
                             input logic [23:0] rgb);
      req_type it;
      it.func = FUNC_LOAD;
      it.pos_col = col[7:0];
      it.pos_row = row[7:0];
      {it.in_red, it.in_green, it.in_blue} = rgb;
      send_item(it);
   endtask

   task automatic request_pixel(input int col, input int row);
      req_type it;
      it.func = FUNC_REQUEST;
      it.pos_col = col[7:0];
      it.pos_row = row[7:0];
      {it.in_red, it.in_green, it.in_blue} = 24'($urandom());
      send_item(it);
   endtask

   // Loads every pixel of a w by h source image with random colors.
   task automatic load_frame(input int w, input int h);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++)
            load_pixel(c, r, 24'($urandom()));
   endtask

   task automatic set_geometry(input int w, input int h);
      write_reg(REG_SRC_WIDTH, w);
      write_reg(REG_SRC_HEIGHT, h);
   endtask

   task automatic set_matrix(input logic [31:0] xx, input logic [31:0] xy,
                             input logic [31:0] ox, input logic [31:0] yx,
                             input logic [31:0] yy, input logic [31:0] oy);
      write_reg(REG_COEF_XX, xx);
      write_reg(REG_COEF_XY, xy);
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_COEF_YX, yx);
      write_reg(REG_COEF_YY, yy);
      write_reg(REG_OFFSET_Y, oy);
   endtask

   // Directed: identity, extremes, edges, ignored requests, off-image points.
   task automatic test_directed();
      set_geometry(4, 4);
      load_frame(4, 4);
      load_pixel(255, 255, 24'hFFFFFF);
      load_pixel(0, 0, 24'hFFFFFF);
      request_pixel(0, 0);
      request_pixel(3, 3);
      request_pixel(OUT_SIZE, 0);
      request_pixel(0, 255);
      request_pixel(111, 111);
      idle_channel();
      // Half-pixel shift exercises rounding; large magnitudes saturate.
      set_matrix(32'h0000_8000, 32'h0000_0000, 32'h0000_8080, 32'h0000_0000,
                 32'h0000_8000, 32'h0000_80FF);
      request_pixel(1, 1);
      request_pixel(5, 2);
      idle_channel();
      set_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      request_pixel(0, 0);
      request_pixel(111, 0);
      request_pixel(0, 111);
      request_pixel(111, 111);
      idle_channel();
   endtask

   // Random affine maps over random images; gaps and receiver stalls vary by phase.
   task automatic test_random_warps();
      int w, h, n;
      for (int phase = 0; phase < 12; phase++) begin
         gap_enable = (phase % 3 != 2);
         stall_rand = (phase % 4 != 3);
         case (phase)
            0: begin w = 1; h = 1; end
            1: begin w = 256; h = 1; end
            2: begin w = 1; h = 256; end
            default: begin w = $urandom_range(1, 4); h = $urandom_range(1, 4); end
         endcase
         set_geometry(w, h);
         load_frame(w, h);
         // Random bits in row 255 too, as a stray load off the image unless h is 256.
         load_pixel($urandom_range(0, 255), 255, 24'($urandom()));
         if ($urandom_range(0, 2) == 0)
            set_matrix($urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom());
         else
            set_matrix($urandom_range(0, 65536 * 2) - 65536,
                       $urandom_range(0, 65536) - 32768,
                       $urandom_range(0, 65536 * 8) - 65536 * 2,
                       $urandom_range(0, 65536) - 32768,
                       $urandom_range(0, 65536 * 2) - 65536,
                       $urandom_range(0, 65536 * 8) - 65536 * 2);
         n = 15;
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
               request_pixel($urandom_range(0, 255), $urandom_range(0, 255));
            else
               request_pixel($urandom_range(0, OUT_SIZE - 1), $urandom_range(0, OUT_SIZE - 1));
         end
         idle_channel();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_addr   = REG_COEF_XX;
      csr_wdata  = '0;
      stall_rand = 1'b1;
      gap_enable = 1'b1;
      mat_xx = 32'sd65536; mat_xy = 0; mat_ox = 0;
      mat_yx = 0; mat_yy = 32'sd65536; mat_oy = 0;
      frame_w = 9'd256; frame_h = 9'd256;
      for (int i = 0; i < 65536; i++) begin
         shadow_frame[i] = '0;
      end
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_random_warps();
      if (error_count == 0)
         $display("affine_bilinear_warp regression: pass");
      else
         $display("affine_bilinear_warp regression: fail");
      $finish;
   end
endmodule
